/* design/svm_pkg.sv */
// shared types and constants of the sample voice mixer
// no dependencies
package svm_pkg;

	localparam int VOICES        = 8;
	localparam int RESERVED_SLOT = 6;
	localparam int SAMPLE_DEPTH  = 65536;
	localparam int VIDX_W        = $clog2(VOICES);
	localparam int SAMP_AW       = $clog2(SAMPLE_DEPTH);
	localparam int QUEUE_DEPTH   = 4;
	localparam int QAW           = $clog2(QUEUE_DEPTH);
	localparam int ENV_FRAC_W    = 15;

	localparam logic [15:0] UNITY = 16'h8000;

	typedef enum logic [2:0] {
		OP_WRITE    = 3'd0,
		OP_START    = 3'd1,
		OP_STOP     = 3'd2,
		OP_STOP_ALL = 3'd3,
		OP_TICK     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		KIND_MIX     = 2'd0,
		KIND_STARTED = 2'd1,
		KIND_ENDED   = 2'd2
	} kind_t;

	// classified command word between front and back
	typedef struct packed {
		op_t         op;
		logic [2:0]  slot;
		logic        slot_given;
		logic [15:0] address;
		logic [16:0] length;
		logic [15:0] sample_left;
		logic [15:0] sample_right;
		logic [15:0] start_frame;
		logic [15:0] start_frac;
		logic [19:0] step;
		logic [15:0] gain;
		logic [15:0] fade;
	} cmd_t;

	typedef struct packed {
		logic        start;
		logic [15:0] num;
		logic [15:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quot;
	} div_rsp_t;

endpackage

/* design/svm_intf.sv */
// channel interfaces of the sample voice mixer: command, result, configuration
// no dependencies
interface svm_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic [2:0]         slot;
	logic               slot_given;
	logic [15:0]        address;
	logic [16:0]        length;
	logic signed [15:0] sample_left;
	logic signed [15:0] sample_right;
	logic [15:0]        start_frame;
	logic [15:0]        start_frac;
	logic [19:0]        step;
	logic [15:0]        volume;
	logic [15:0]        fade_frames;

	modport source(output valid, operation, slot, slot_given, address, length, sample_left,
		sample_right, start_frame, start_frac, step, volume, fade_frames, input ready);
	modport sink(input valid, operation, slot, slot_given, address, length, sample_left,
		sample_right, start_frame, start_frac, step, volume, fade_frames, output ready);
endinterface

interface svm_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [2:0]         event_slot;
	logic signed [18:0] mix_left;
	logic signed [18:0] mix_right;
	logic               last;

	modport source(output valid, kind, event_slot, mix_left, mix_right, last, input ready);
	modport sink(input valid, kind, event_slot, mix_left, mix_right, last, output ready);
endinterface

interface svm_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] master_volume;

	modport source(output valid, master_volume, input ready);
	modport sink(input valid, master_volume, output ready);
endinterface

/* design/svm_front.sv */
// front end: accepts command words, drops unknown operations, clamps gain and fade,
// and queues them for the back end; uses svm_pkg and svm_cmd_if
module svm_front (
	input  logic          clk,
	input  logic          arst_n,
	svm_cmd_if.sink       cmd,
	output svm_pkg::cmd_t q_data,
	output logic          q_valid,
	input  logic          q_pop
);

	svm_pkg::cmd_t              fifo_q [svm_pkg::QUEUE_DEPTH];
	logic [svm_pkg::QAW-1:0]    wr_q;
	logic [svm_pkg::QAW-1:0]    rd_q;
	logic [svm_pkg::QAW:0]      count_q;
	svm_pkg::cmd_t              word;
	logic                       known;
	logic                       push;
	logic                       pop;

	assign cmd.ready = (count_q != (svm_pkg::QAW+1)'(svm_pkg::QUEUE_DEPTH));
	assign known     = (cmd.operation <= 3'(svm_pkg::OP_TICK));
	assign push      = cmd.valid && cmd.ready && known;
	assign q_valid   = (count_q != '0);
	assign pop       = q_pop && q_valid;
	assign q_data    = fifo_q[rd_q];

	always_comb begin
		word              = '0;
		word.op           = svm_pkg::op_t'(cmd.operation);
		word.slot         = cmd.slot;
		word.slot_given   = cmd.slot_given;
		word.address      = cmd.address;
		word.length       = cmd.length;
		word.sample_left  = cmd.sample_left;
		word.sample_right = cmd.sample_right;
		word.start_frame  = cmd.start_frame;
		word.start_frac   = cmd.start_frac;
		word.step         = cmd.step;
		// gain clamped to unity, zero fade acts as one frame
		word.gain = (cmd.volume > svm_pkg::UNITY) ? svm_pkg::UNITY : cmd.volume;
		word.fade = (cmd.fade_frames == '0) ? 16'd1 : cmd.fade_frames;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= word;
	end

endmodule

/* design/svm_div.sv */
// envelope divider: floor(num * 32768 / den) for num <= den, one quotient bit per cycle
// uses svm_pkg
module svm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  svm_pkg::div_req_t req,
	output svm_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic [3:0]  cnt_q;
	logic        done_q;
	logic [15:0] rem_q;
	logic [15:0] den_q;
	logic [15:0] quot_q;
	logic [16:0] r2;
	logic        ge;

	assign r2       = {rem_q, 1'b0};
	assign ge       = (r2 >= {1'b0, den_q});
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(svm_pkg::ENV_FRAC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			// integer bit is 0 or 1 since num never exceeds den
			if (req.num >= req.den) begin
				rem_q  <= req.num - req.den;
				quot_q <= 16'd1;
			end else begin
				rem_q  <= req.num;
				quot_q <= 16'd0;
			end
		end else if (busy_q) begin
			rem_q  <= ge ? 16'(r2 - {1'b0, den_q}) : r2[15:0];
			quot_q <= {quot_q[14:0], ge};
		end
	end

endmodule

/* design/svm_back.sv */
// back end: sample memory, voice state and the tick sequencer with output register
// uses svm_pkg and svm_res_if; drives the svm_div envelope divider through its ports
module svm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  svm_pkg::cmd_t     cmd,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	input  logic [15:0]       master,
	output svm_pkg::div_req_t div_req,
	input  svm_pkg::div_rsp_t div_rsp,
	svm_res_if.source         res
);

	typedef enum logic [3:0] {
		B_IDLE, B_VCHK, B_RD1, B_ENV, B_DIV, B_GAIN1, B_GAIN2, B_MUL, B_ACC, B_NEXT, B_OUT
	} state_t;

	localparam int VW = svm_pkg::VIDX_W;

	state_t                       state_q;
	state_t                       ret_q;
	logic [VW-1:0]                vs_q;
	logic [svm_pkg::VOICES-1:0]   active_q;

	logic [15:0] base_q  [svm_pkg::VOICES];
	logic [16:0] len_q   [svm_pkg::VOICES];
	logic [20:0] pos_q   [svm_pkg::VOICES];
	logic [15:0] frac_q  [svm_pkg::VOICES];
	logic [19:0] step_q  [svm_pkg::VOICES];
	logic [15:0] gain_q  [svm_pkg::VOICES];
	logic [15:0] fade_q  [svm_pkg::VOICES];
	logic [15:0] start_q [svm_pkg::VOICES];

	logic [31:0] mem [svm_pkg::SAMPLE_DEPTH];
	logic [31:0] rdata_q;
	logic [31:0] w0_q;

	logic signed [33:0] p0l_q, p1l_q, p0r_q, p1r_q;
	logic signed [33:0] il_q, ir_q;
	logic signed [50:0] prodl_q, prodr_q;
	logic [15:0]        env_q, vg_q, g_q;
	logic signed [19:0] accl_q, accr_q;

	logic               out_valid_q;
	svm_pkg::kind_t     kind_q;
	logic [2:0]         eslot_q;
	logic signed [18:0] mixl_q, mixr_q;
	logic               last_q;

	logic [20:0] cur_pos;
	logic [16:0] cur_len;
	logic [15:0] cur_frac, cur_fade, cur_start, cur_base;
	logic        ended;
	logic [17:0] pos_p1;
	logic [16:0] i1;
	logic [svm_pkg::SAMP_AW-1:0] raddr;
	logic [20:0] addr0, addr1, rel;
	logic        in_fade_in, near_end, need_div;
	logic [16:0] remain;
	logic signed [17:0] wa, wb;
	logic signed [15:0] s0l, s0r, s1l, s1r;
	logic [31:0] vg_full, g_full;
	logic signed [16:0] gs;
	logic signed [50:0] rsuml, rsumr;
	logic signed [19:0] rl, rr;
	logic [20:0] fsum;
	logic        pick_ok;
	logic [VW-1:0] pick;
	logic        stop_ok;
	logic        is_cmd;

	function automatic logic signed [18:0] sat19(input logic signed [19:0] v);
		if (v > 20'sd262143) return 19'sh3FFFF;
		if (v < -20'sd262144) return 19'sh40000;
		return v[18:0];
	endfunction

	assign cur_pos   = pos_q[vs_q];
	assign cur_len   = len_q[vs_q];
	assign cur_frac  = frac_q[vs_q];
	assign cur_fade  = fade_q[vs_q];
	assign cur_start = start_q[vs_q];
	assign cur_base  = base_q[vs_q];

	assign ended  = ({4'b0, cur_len} <= cur_pos);
	assign pos_p1 = {1'b0, cur_pos[16:0]} + 18'd1;
	// second tap holds on the last frame of the region
	assign i1     = (pos_p1 < {1'b0, cur_len}) ? pos_p1[16:0] : cur_len - 17'd1;
	assign addr0  = {5'b0, cur_base} + cur_pos;
	assign addr1  = {5'b0, cur_base} + {4'b0, i1};
	assign raddr  = (state_q == B_RD1) ? addr1[svm_pkg::SAMP_AW-1:0]
		: addr0[svm_pkg::SAMP_AW-1:0];

	// fade-in by frames since start, fade-out by frames left
	assign rel        = cur_pos - {5'b0, cur_start};
	assign in_fade_in = (rel < {5'b0, cur_fade});
	assign near_end   = ({1'b0, cur_pos} + {6'b0, cur_fade}) >= {5'b0, cur_len};
	assign remain     = cur_len - cur_pos[16:0];
	assign need_div   = in_fade_in || near_end;

	assign div_req.start = (state_q == B_ENV) && need_div;
	assign div_req.num   = in_fade_in ? rel[15:0] : remain[15:0];
	assign div_req.den   = cur_fade;

	assign s0l = w0_q[15:0];
	assign s0r = w0_q[31:16];
	assign s1l = rdata_q[15:0];
	assign s1r = rdata_q[31:16];
	assign wa  = 18'sd65536 - $signed({2'b0, cur_frac});
	assign wb  = $signed({2'b0, cur_frac});

	assign vg_full = 32'(gain_q[vs_q]) * 32'(env_q) + 32'd16384;
	assign g_full  = 32'(vg_q) * 32'(master) + 32'd16384;
	assign gs      = $signed({1'b0, g_q});

	assign rsuml = prodl_q + (51'sd1 <<< 30);
	assign rsumr = prodr_q + (51'sd1 <<< 30);
	assign rl    = rsuml[50:31];
	assign rr    = rsumr[50:31];

	assign fsum = {5'b0, cur_frac} + {1'b0, step_q[vs_q]};

	assign is_cmd  = (state_q == B_IDLE) && cmd_valid;
	assign cmd_pop = is_cmd;
	assign stop_ok = (int'(cmd.slot) < svm_pkg::VOICES) && active_q[VW'(cmd.slot)];

	// requested slot first, else lowest free slot that is not reserved
	always_comb begin
		pick_ok = 1'b0;
		pick    = '0;
		if (cmd.slot_given && (int'(cmd.slot) < svm_pkg::VOICES)
			&& !active_q[VW'(cmd.slot)]) begin
			pick_ok = 1'b1;
			pick    = VW'(cmd.slot);
		end else begin
			for (int i = svm_pkg::VOICES - 1; i >= 0; i--) begin
				if (i != svm_pkg::RESERVED_SLOT && !active_q[i]) begin
					pick_ok = 1'b1;
					pick    = VW'(i);
				end
			end
		end
	end

	assign res.valid      = out_valid_q;
	assign res.kind       = kind_q;
	assign res.event_slot = eslot_q;
	assign res.mix_left   = mixl_q;
	assign res.mix_right  = mixr_q;
	assign res.last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			ret_q       <= B_IDLE;
			vs_q        <= '0;
			active_q    <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= svm_pkg::KIND_MIX;
			eslot_q     <= '0;
			mixl_q      <= '0;
			mixr_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							svm_pkg::OP_START: begin
								if (pick_ok) begin
									active_q[pick] <= 1'b1;
									out_valid_q    <= 1'b1;
									kind_q         <= svm_pkg::KIND_STARTED;
									eslot_q        <= 3'(pick);
									mixl_q         <= '0;
									mixr_q         <= '0;
									last_q         <= 1'b1;
									ret_q          <= B_IDLE;
									state_q        <= B_OUT;
								end
							end
							svm_pkg::OP_STOP: begin
								if (stop_ok) begin
									active_q[VW'(cmd.slot)] <= 1'b0;
									out_valid_q <= 1'b1;
									kind_q      <= svm_pkg::KIND_ENDED;
									eslot_q     <= cmd.slot;
									mixl_q      <= '0;
									mixr_q      <= '0;
									last_q      <= 1'b1;
									ret_q       <= B_IDLE;
									state_q     <= B_OUT;
								end
							end
							svm_pkg::OP_STOP_ALL: active_q <= '0;
							svm_pkg::OP_TICK: begin
								vs_q    <= '0;
								state_q <= B_VCHK;
							end
							default: ;
						endcase
					end
				end
				B_VCHK: begin
					if (!active_q[vs_q]) begin
						state_q <= B_NEXT;
					end else if (ended) begin
						active_q[vs_q] <= 1'b0;
						out_valid_q    <= 1'b1;
						kind_q         <= svm_pkg::KIND_ENDED;
						eslot_q        <= 3'(vs_q);
						mixl_q         <= '0;
						mixr_q         <= '0;
						last_q         <= 1'b0;
						ret_q          <= B_NEXT;
						state_q        <= B_OUT;
					end else begin
						state_q <= B_RD1;
					end
				end
				B_RD1: state_q <= B_ENV;
				B_ENV: state_q <= need_div ? B_DIV : B_GAIN1;
				B_DIV: if (div_rsp.done) state_q <= B_GAIN1;
				B_GAIN1: state_q <= B_GAIN2;
				B_GAIN2: state_q <= B_MUL;
				B_MUL: state_q <= B_ACC;
				B_ACC: state_q <= B_NEXT;
				B_NEXT: begin
					if (vs_q == VW'(svm_pkg::VOICES - 1)) begin
						out_valid_q <= 1'b1;
						kind_q      <= svm_pkg::KIND_MIX;
						eslot_q     <= '0;
						mixl_q      <= sat19(accl_q);
						mixr_q      <= sat19(accr_q);
						last_q      <= 1'b1;
						ret_q       <= B_IDLE;
						state_q     <= B_OUT;
					end else begin
						vs_q    <= vs_q + 1'b1;
						state_q <= B_VCHK;
					end
				end
				B_OUT: begin
					if (res.ready) begin
						out_valid_q <= 1'b0;
						state_q     <= ret_q;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (is_cmd && cmd.op == svm_pkg::OP_WRITE)
			mem[svm_pkg::SAMP_AW'(cmd.address)] <= {cmd.sample_right, cmd.sample_left};
		rdata_q <= mem[raddr];

		if (is_cmd && cmd.op == svm_pkg::OP_START && pick_ok) begin
			base_q[pick]  <= cmd.address;
			len_q[pick]   <= cmd.length;
			pos_q[pick]   <= {5'b0, cmd.start_frame};
			frac_q[pick]  <= cmd.start_frac;
			start_q[pick] <= cmd.start_frame;
			step_q[pick]  <= cmd.step;
			gain_q[pick]  <= cmd.gain;
			fade_q[pick]  <= cmd.fade;
		end
		if (is_cmd && cmd.op == svm_pkg::OP_TICK) begin
			accl_q <= '0;
			accr_q <= '0;
		end

		case (state_q)
			B_RD1: w0_q <= rdata_q;
			B_ENV: begin
				p0l_q <= 34'(s0l) * 34'(wa);
				p1l_q <= 34'(s1l) * 34'(wb);
				p0r_q <= 34'(s0r) * 34'(wa);
				p1r_q <= 34'(s1r) * 34'(wb);
				if (!need_div) env_q <= svm_pkg::UNITY;
			end
			B_DIV: if (div_rsp.done) env_q <= div_rsp.quot;
			B_GAIN1: begin
				vg_q <= vg_full[30:15];
				il_q <= p0l_q + p1l_q;
				ir_q <= p0r_q + p1r_q;
			end
			B_GAIN2: g_q <= g_full[30:15];
			B_MUL: begin
				prodl_q <= 51'(il_q) * 51'(gs);
				prodr_q <= 51'(ir_q) * 51'(gs);
			end
			B_ACC: begin
				accl_q        <= accl_q + rl;
				accr_q        <= accr_q + rr;
				pos_q[vs_q]   <= cur_pos + {16'b0, fsum[20:16]};
				frac_q[vs_q]  <= fsum[15:0];
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_OUT) |-> out_valid_q)
		else $error("result stage without a pending word");
	a_mix_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == svm_pkg::KIND_MIX) |-> last_q)
		else $error("mix frame not marked last");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == B_DIV))
		else $error("divider finished outside the wait state");
	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_GAIN1) |-> (env_q <= svm_pkg::UNITY))
		else $error("envelope above unity");
`endif

endmodule

/* design/sample_voice_mixer.sv */
// commands: write and stop-all give no word; a started voice or a stopped active voice gives one word
// tick: each voice is checked; an active one reads two frames, waits on the envelope divider inside
//   a fade, is scaled and summed; each ended voice gives an ended word; the mix word comes last
// throughput: one item at a time in the back end, sample memory with one write and one read port;
//   the 4-word command queue keeps taking words while results wait, until it is full
// reset: arst_n clears the queue, voice activity and pending result; master volume to unity
module sample_voice_mixer (
	input logic       clk,
	input logic       arst_n,
	svm_cmd_if.sink   cmd,
	svm_res_if.source res,
	svm_cfg_if.sink   cfg
);

	// master volume register, writes are always taken
	logic [15:0]       master_q;
	logic [15:0]       master_eff;

	// queue between the front and the back end
	svm_pkg::cmd_t     q_data;
	logic              q_valid;
	logic              q_pop;

	// envelope divider request and answer
	svm_pkg::div_req_t div_req;
	svm_pkg::div_rsp_t div_rsp;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= svm_pkg::UNITY;
		end else if (cfg.valid) begin
			master_q <= cfg.master_volume;
		end
	end

	// values above unity act as unity
	assign master_eff = (master_q > svm_pkg::UNITY) ? svm_pkg::UNITY : master_q;

	// front: accept, classify and queue command words
	svm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_data  (q_data),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	// back: sample memory, voice table, tick sequencer and result register
	svm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_data),
		.cmd_valid (q_valid),
		.cmd_pop   (q_pop),
		.master    (master_eff),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.res       (res)
	);

	// bit-serial envelope divider shared by all voices
	svm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

/* tb/sample_voice_mixer_test.sv */
`timescale 1ns / 100ps
// self-checking bench for sample_voice_mixer: random and directed command words against a
// cycle-free predictor of the mixer, with random idling on both channels
// depends on svm_pkg, the svm_*_if interfaces and the sample_voice_mixer top level
module sample_voice_mixer_test;
	import svm_pkg::*;

	// operation code that the block must ignore
	localparam logic [2:0] OP_UNUSED = 3'd7;
	// every region that a voice reads lies inside this wrapped window of frames,
	// all of them loaded before the first start
	localparam logic [15:0] POOL_LO   = 16'hFFF0;
	localparam int          POOL_SIZE = 32;
	localparam int          HOLD_CYCLES = 300;
	// worst tick: eight voices inside a fade, plus ended words and the mix word
	localparam int          DRAIN_CYCLES = 300;
	localparam int          STALL_LIMIT = 5000;

	typedef struct {
		logic [2:0]  op;
		logic [2:0]  slot;
		logic        given;
		logic [15:0] addr;
		logic [16:0] len;
		logic [15:0] left;
		logic [15:0] right;
		logic [15:0] frame;
		logic [15:0] frac;
		logic [19:0] step;
		logic [15:0] vol;
		logic [15:0] fade;
	} voice_cmd_t;

	typedef struct {
		logic [1:0]  kind;
		logic [2:0]  slot;
		logic [18:0] left;
		logic [18:0] right;
		logic        last;
	} mixer_word_t;

	logic clk;
	logic arst_n;

	svm_cmd_if cmd_bus();
	svm_res_if res_bus();
	svm_cfg_if cfg_bus();

	sample_voice_mixer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.res(res_bus),
		.cfg(cfg_bus)
	);

	// words still to send, and mixer output still owed
	voice_cmd_t  cmd_backlog[$];
	mixer_word_t owed_words[$];
	int          error_count = 0;
	bit          calm = 0;          // no idling on either side
	bit          hold_request = 0;  // ask the receiver for one long hold-off

	// predictor state
	logic [31:0] frame_mem [0:SAMPLE_DEPTH-1];
	bit          v_active [VOICES];
	logic [15:0] v_base [VOICES];
	logic [16:0] v_len [VOICES];
	logic [20:0] v_pos [VOICES];
	logic [15:0] v_frac [VOICES];
	logic [19:0] v_step [VOICES];
	logic [15:0] v_gain [VOICES];
	logic [15:0] v_fade [VOICES];
	logic [15:0] v_start [VOICES];
	logic [15:0] master_gain = UNITY;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic longint round_q31(longint x);
		return (x + (64'sd1 <<< 30)) >>> 31;
	endfunction

	function automatic longint clamp19(longint v);
		if (v > 262143)
			return 262143;
		if (v < -262144)
			return -262144;
		return v;
	endfunction

	function automatic mixer_word_t event_word(logic [1:0] kind, int s, logic last);
		mixer_word_t w;
		w.kind  = kind;
		w.slot  = 3'(s);
		w.left  = '0;
		w.right = '0;
		w.last  = last;
		return w;
	endfunction

	// one mixer tick: ended voices in slot order, then the mix word
	task automatic mix_tick();
		longint acc_l, acc_r, il, ir, f;
		longint unsigned fi, ln, i1, rel, env, vg, g, mg, sum;
		logic [31:0] w0, w1;
		mixer_word_t w;
		acc_l = 0;
		acc_r = 0;
		mg = (master_gain > UNITY) ? UNITY : master_gain;
		for (int s = 0; s < VOICES; s++) begin
			if (!v_active[s])
				continue;
			fi = v_pos[s];
			ln = v_len[s];
			if (fi >= ln) begin
				v_active[s] = 0;
				owed_words.push_back(event_word(KIND_ENDED, s, 1'b0));
				continue;
			end
			i1 = (fi + 1 < ln) ? fi + 1 : ln - 1;
			w0 = frame_mem[16'(v_base[s] + fi)];
			w1 = frame_mem[16'(v_base[s] + i1)];
			f  = v_frac[s];
			il = longint'($signed(w0[15:0])) * (65536 - f) + longint'($signed(w1[15:0])) * f;
			ir = longint'($signed(w0[31:16])) * (65536 - f) + longint'($signed(w1[31:16])) * f;
			// linear fade-in from the start offset, fade-out toward the region end
			rel = (fi - v_start[s]) & 21'h1FFFFF;
			env = UNITY;
			if (rel < v_fade[s])
				env = rel * UNITY / v_fade[s];
			else if (fi + v_fade[s] >= ln)
				env = (ln - fi) * UNITY / v_fade[s];
			if (env > UNITY)
				env = UNITY;
			vg = (v_gain[s] * env + 16384) >> 15;
			g  = (vg * mg + 16384) >> 15;
			acc_l += round_q31(il * longint'(g));
			acc_r += round_q31(ir * longint'(g));
			sum = v_frac[s] + v_step[s];
			v_pos[s]  = 21'(fi + (sum >> 16));
			v_frac[s] = 16'(sum);
		end
		w.kind  = KIND_MIX;
		w.slot  = '0;
		w.left  = 19'(clamp19(acc_l));
		w.right = 19'(clamp19(acc_r));
		w.last  = 1'b1;
		owed_words.push_back(w);
	endtask

	// update the predictor with one accepted word and queue what it owes
	task automatic apply_cmd(voice_cmd_t c);
		int pick;
		pick = -1;
		case (c.op)
			OP_WRITE: begin
				frame_mem[c.addr] = {c.right, c.left};
			end
			OP_START: begin
				if (c.given && !v_active[c.slot])
					pick = c.slot;
				else
					for (int i = 0; i < VOICES; i++)
						if (i != RESERVED_SLOT && !v_active[i]) begin
							pick = i;
							break;
						end
				if (pick >= 0) begin
					v_active[pick] = 1;
					v_base[pick]   = c.addr;
					v_len[pick]    = c.len;
					v_pos[pick]    = c.frame;
					v_frac[pick]   = c.frac;
					v_start[pick]  = c.frame;
					v_step[pick]   = c.step;
					v_gain[pick]   = (c.vol > UNITY) ? UNITY : c.vol;
					v_fade[pick]   = (c.fade == 0) ? 16'd1 : c.fade;
					owed_words.push_back(event_word(KIND_STARTED, pick, 1'b1));
				end
			end
			OP_STOP: begin
				if (v_active[c.slot]) begin
					v_active[c.slot] = 0;
					owed_words.push_back(event_word(KIND_ENDED, c.slot, 1'b1));
				end
			end
			OP_STOP_ALL: begin
				for (int i = 0; i < VOICES; i++)
					v_active[i] = 0;
			end
			OP_TICK: mix_tick();
			default: ;
		endcase
	endtask

	function automatic voice_cmd_t blank_cmd(logic [2:0] op);
		voice_cmd_t c;
		c.op    = op;
		c.slot  = 3'($urandom);
		c.given = 1'($urandom);
		c.addr  = 16'($urandom);
		c.len   = 17'($urandom);
		c.left  = 16'($urandom);
		c.right = 16'($urandom);
		c.frame = 16'($urandom);
		c.frac  = 16'($urandom);
		c.step  = 20'($urandom);
		c.vol   = 16'($urandom);
		c.fade  = 16'($urandom);
		return c;
	endfunction

	// start word whose playable frames all fall in the loaded window;
	// a start offset at or past the length reads nothing
	function automatic voice_cmd_t start_cmd(logic given, logic [2:0] slot, logic [16:0] len,
		logic [15:0] frame, logic [19:0] step, logic [15:0] vol, logic [15:0] fade);
		voice_cmd_t c;
		int span;
		c = blank_cmd(OP_START);
		c.given = given;
		c.slot  = slot;
		c.len   = len;
		c.frame = frame;
		c.step  = step;
		c.vol   = vol;
		c.fade  = fade;
		if (frame < len) begin
			span   = len - frame;
			c.addr = POOL_LO + 16'($urandom_range(0, POOL_SIZE - span)) - frame;
		end
		return c;
	endfunction

	function automatic voice_cmd_t random_start();
		logic [16:0] len;
		logic [15:0] frame;
		logic [19:0] step;
		int span;
		len = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(1, 65536))
			: 17'($urandom_range(1, 40));
		if ($urandom_range(0, 9) == 0) begin
			frame = 16'($urandom_range(len > 65535 ? 65535 : len, 65535));
		end else begin
			span  = $urandom_range(1, (len < POOL_SIZE) ? len : POOL_SIZE);
			frame = 16'(len - span);
		end
		step = ($urandom_range(0, 4) == 0) ? 20'($urandom) : 20'($urandom_range(0, 20'h4FFFF));
		return start_cmd(1'($urandom), 3'($urandom), len, frame, step,
			16'($urandom_range(0, 32768)),
			($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
				: 16'($urandom_range(1, 40)));
	endfunction

	function automatic voice_cmd_t random_cmd();
		voice_cmd_t c;
		int r;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			c = blank_cmd(OP_WRITE);
			if ($urandom_range(0, 1))
				c.addr = POOL_LO + 16'($urandom_range(0, POOL_SIZE - 1));
		end else if (r < 38)
			c = random_start();
		else if (r < 48)
			c = blank_cmd(OP_STOP);
		else if (r < 51)
			c = blank_cmd(OP_STOP_ALL);
		else if (r < 53)
			c = blank_cmd(3'($urandom_range(5, 7)));
		else
			c = blank_cmd(OP_TICK);
		return c;
	endfunction

	task automatic add_random(int n);
		for (int i = 0; i < n; i++)
			cmd_backlog.push_back(random_cmd());
	endtask

	task automatic add_directed();
		voice_cmd_t c;
		// load the window, extremes of both channels at the edges
		for (int i = 0; i < POOL_SIZE; i++) begin
			c = blank_cmd(OP_WRITE);
			c.addr = POOL_LO + 16'(i);
			if (i == 0) begin
				c.left  = 16'h8000;
				c.right = 16'h7FFF;
			end else if (i == POOL_SIZE - 1) begin
				c.left  = 16'h7FFF;
				c.right = 16'h8000;
			end
			cmd_backlog.push_back(c);
		end
		// reserved slot when asked for by name, then any free slot
		cmd_backlog.push_back(start_cmd(1'b1, 3'(RESERVED_SLOT), 17'd20, 16'd0, 20'h10000,
			16'd32768, 16'd4));
		cmd_backlog.push_back(start_cmd(1'b0, 3'd0, 17'd0, 16'd0, 20'h0, 16'd100, 16'd1));
		cmd_backlog.push_back(start_cmd(1'b0, 3'd0, 17'd65536, 16'd65530, 20'hFFFFF,
			16'hFFFF, 16'd0));
		cmd_backlog.push_back(start_cmd(1'b1, 3'd7, 17'd30, 16'd2, 20'h0, 16'd0, 16'hFFFF));
		cmd_backlog.push_back(blank_cmd(OP_TICK));
		cmd_backlog.push_back(blank_cmd(OP_TICK));
		c = blank_cmd(OP_STOP);
		c.slot = 3'(RESERVED_SLOT);
		cmd_backlog.push_back(c);
		cmd_backlog.push_back(c);   // second stop hits an idle slot
		cmd_backlog.push_back(blank_cmd(OP_UNUSED));
		// fill every slot but the reserved one, then the last two starts find none
		for (int i = 0; i < 8; i++)
			cmd_backlog.push_back(start_cmd(1'b0, 3'd0, 17'd32, 16'd0, 20'h08000,
				16'd32768, 16'd8));
		cmd_backlog.push_back(blank_cmd(OP_TICK));
		cmd_backlog.push_back(blank_cmd(OP_STOP_ALL));
		cmd_backlog.push_back(blank_cmd(OP_TICK));
	endtask

	// command driver
	int gap_left = 0;
	always @(posedge clk) begin
		voice_cmd_t c;
		logic next_valid;
		if (arst_n) begin
			next_valid = cmd_bus.valid;
			if (cmd_bus.valid && cmd_bus.ready) begin
				apply_cmd(cmd_backlog.pop_front());
				next_valid = 0;
			end
			if (!next_valid) begin
				if (gap_left > 0)
					gap_left--;
				else if (cmd_backlog.size() > 0) begin
					if (!calm && $urandom_range(0, 7) == 0)
						gap_left = $urandom_range(0, 4);
					else begin
						c = cmd_backlog[0];
						cmd_bus.operation    <= c.op;
						cmd_bus.slot         <= c.slot;
						cmd_bus.slot_given   <= c.given;
						cmd_bus.address      <= c.addr;
						cmd_bus.length       <= c.len;
						cmd_bus.sample_left  <= c.left;
						cmd_bus.sample_right <= c.right;
						cmd_bus.start_frame  <= c.frame;
						cmd_bus.start_frac   <= c.frac;
						cmd_bus.step         <= c.step;
						cmd_bus.volume       <= c.vol;
						cmd_bus.fade_frames  <= c.fade;
						next_valid = 1;
					end
				end
			end
			cmd_bus.valid <= next_valid;
		end
	end

	// result monitor and receiver stalls
	int hold_left = 0;
	int stall_left = 0;
	always @(posedge clk) begin
		mixer_word_t want;
		if (arst_n) begin
			if (res_bus.valid && res_bus.ready) begin
				if (owed_words.size() == 0) begin
					$display("%0t: unexpected word kind=%0d slot=%0d l=%0d r=%0d last=%0d",
						$time, res_bus.kind, res_bus.event_slot, res_bus.mix_left,
						res_bus.mix_right, res_bus.last);
					error_count++;
				end else begin
					want = owed_words.pop_front();
					if (res_bus.kind !== want.kind || res_bus.event_slot !== want.slot ||
						res_bus.mix_left !== want.left || res_bus.mix_right !== want.right ||
						res_bus.last !== want.last) begin
						$display("%0t: expected kind=%0d slot=%0d l=%0d r=%0d last=%0d",
							$time, want.kind, want.slot, $signed(want.left),
							$signed(want.right), want.last);
						$display("%0t:   actual kind=%0d slot=%0d l=%0d r=%0d last=%0d",
							$time, res_bus.kind, res_bus.event_slot, res_bus.mix_left,
							res_bus.mix_right, res_bus.last);
						error_count++;
					end
				end
			end
			if (hold_request) begin
				hold_request = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_bus.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 4);
				res_bus.ready <= 1'b0;
			end else
				res_bus.ready <= 1'b1;
		end
	end

	// watchdog: too long without any word moving on any channel
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
			(cfg_bus.valid && cfg_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// wait for every word sent and every owed word back, then let the back end settle
	task automatic drain();
		while (cmd_backlog.size() > 0 || cmd_bus.valid || owed_words.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_master(logic [15:0] value);
		@(posedge clk);
		cfg_bus.master_volume <= value;
		cfg_bus.valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		master_gain = value;
		cfg_bus.valid <= 1'b0;
	endtask

	initial begin
		logic [15:0] settings [5];
		settings = '{16'd0, 16'hFFFF, 16'd1, UNITY, 16'($urandom)};
		cmd_bus.valid = 0;
		cmd_bus.operation = OP_TICK;
		cmd_bus.slot = 0;
		cmd_bus.slot_given = 0;
		cmd_bus.address = 0;
		cmd_bus.length = 0;
		cmd_bus.sample_left = 0;
		cmd_bus.sample_right = 0;
		cmd_bus.start_frame = 0;
		cmd_bus.start_frac = 0;
		cmd_bus.step = 0;
		cmd_bus.volume = 0;
		cmd_bus.fade_frames = 0;
		res_bus.ready = 0;
		cfg_bus.valid = 0;
		cfg_bus.master_volume = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// master volume at its reset value of unity
		add_directed();
		add_random(60);
		drain();

		foreach (settings[i]) begin
			write_master(settings[i]);
			@(negedge clk);
			if (i == $size(settings) - 1)
				calm = 1;
			add_random(60);
			// receiver holds off so the command queue fills and backs up
			if (i == 0)
				hold_request = 1;
			drain();
		end

		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
design/svm_pkg.sv
design/svm_intf.sv
design/svm_front.sv
design/svm_div.sv
design/svm_back.sv
design/sample_voice_mixer.sv
tb/sample_voice_mixer_test.sv
